// ===== hdl/ack_retransmit_backoff_controller_unit_defines.svh =====
// Assertion macros used by the port-level checker of the backoff controller.
`ifndef ACK_RETRANSMIT_BACKOFF_CONTROLLER_UNIT_DEFINES_SVH
`define ACK_RETRANSMIT_BACKOFF_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ARBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define ARBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/arbc_pkg.sv =====
// Types and constants of the retransmission backoff controller.
package arbc_pkg;

	localparam int unsigned TimeW  = 16;
	localparam int unsigned RetryW = 8;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 16;

	localparam logic [TimeW-1:0]  FirstTimeoutRst = 16'd3;
	localparam logic [TimeW-1:0]  TimeoutCapRst   = 16'd15;
	localparam logic [RetryW-1:0] RetryLimitRst   = 8'd5;
	localparam logic [RetryW-1:0] RetryMax        = 8'hFF;

	typedef enum logic [1:0] {
		OP_START     = 2'd0,
		OP_TICK      = 2'd1,
		OP_RESPONSE  = 2'd2,
		OP_INTERRUPT = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		RSP_ACCEPTED  = 2'd0,
		RSP_MALFORMED = 2'd1,
		RSP_REJECTED  = 2'd2,
		RSP_FATAL     = 2'd3
	} resp_kind_t;

	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_TRANSMIT = 3'd1,
		ACT_SUCCESS  = 3'd2,
		ACT_FAILURE  = 3'd3,
		ACT_DEAD     = 3'd4
	} action_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FIRST_TIMEOUT = 2'd0,
		CFG_TIMEOUT_CAP   = 2'd1,
		CFG_RETRY_LIMIT   = 2'd2,
		CFG_UNUSED        = 2'd3
	} cfg_idx_t;

endpackage

// ===== hdl/ack_retransmit_backoff_controller_unit.sv =====
// Retransmission controller with exponential backoff for one acknowledged request.
// Events (start, tick, response, interrupt) enter through an input register and are applied
// to the controller state when the result register is free or drains, which also loads the
// result register, so one event is taken every cycle unless the result side stalls.
// The state update is combinational: retry count increment, wait doubling
// with a 16-bit cap compare, and countdown decrement. The output register holds a result
// until it is taken while the input register holds the next request, so a stall on the
// result side reaches the input side one request later. Configuration registers are written
// through a plain write port; first_timeout is sampled at start, the cap and retry limit are
// read at each retry.
module ack_retransmit_backoff_controller_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic [1:0]                          response_kind,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          action,
	output logic [arbc_pkg::RetryW-1:0]         retry_count,
	output logic [arbc_pkg::TimeW-1:0]          wait_now,
	input  logic                                cfg_we,
	input  logic [arbc_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [arbc_pkg::CfgDataW-1:0]       cfg_data
);

	logic [arbc_pkg::TimeW-1:0]  first_timeout_q;
	logic [arbc_pkg::TimeW-1:0]  timeout_cap_q;
	logic [arbc_pkg::RetryW-1:0] retry_limit_q;

	logic                        valid_s1;
	arbc_pkg::opcode_t           opcode_s1;
	arbc_pkg::resp_kind_t        kind_s1;

	logic                        busy_q;
	logic [arbc_pkg::RetryW-1:0] retries_q;
	logic [arbc_pkg::TimeW-1:0]  wait_q;
	logic [arbc_pkg::TimeW-1:0]  count_q;

	logic                        out_valid_q;
	arbc_pkg::action_t           action_q;
	logic [arbc_pkg::RetryW-1:0] retry_count_q;
	logic [arbc_pkg::TimeW-1:0]  wait_now_q;

	logic                        advance;
	logic                        in_fire;

	logic                        busy_d;
	logic [arbc_pkg::RetryW-1:0] retries_d;
	logic [arbc_pkg::TimeW-1:0]  wait_d;
	logic [arbc_pkg::TimeW-1:0]  count_d;
	arbc_pkg::action_t           action_d;

	logic [arbc_pkg::RetryW-1:0] retry_inc;
	logic [arbc_pkg::TimeW:0]    doubled;
	logic [arbc_pkg::TimeW-1:0]  capped;
	logic                        retry_tx;

	// The event in the input register moves on whenever the result register is free or drains.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_timeout_q <= arbc_pkg::FirstTimeoutRst;
			timeout_cap_q   <= arbc_pkg::TimeoutCapRst;
			retry_limit_q   <= arbc_pkg::RetryLimitRst;
		end else if (cfg_we) begin
			case (arbc_pkg::cfg_idx_t'(cfg_index))
				arbc_pkg::CFG_FIRST_TIMEOUT: first_timeout_q <= cfg_data;
				arbc_pkg::CFG_TIMEOUT_CAP:   timeout_cap_q   <= cfg_data;
				arbc_pkg::CFG_RETRY_LIMIT:   retry_limit_q   <= cfg_data[arbc_pkg::RetryW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			opcode_s1 <= arbc_pkg::opcode_t'(opcode);
			kind_s1   <= arbc_pkg::resp_kind_t'(response_kind);
		end
	end

	// Shared retry step: saturating count, doubled wait in 17 bits, then the cap.
	always_comb begin
		retry_inc = (retries_q == arbc_pkg::RetryMax) ? retries_q : retries_q + 1'b1;
		doubled   = {wait_q, 1'b0};
		capped    = (doubled > {1'b0, timeout_cap_q}) ? timeout_cap_q
		                                              : doubled[arbc_pkg::TimeW-1:0];
		retry_tx  = retry_inc < retry_limit_q;
	end

	always_comb begin
		logic do_retry;
		logic expired;
		busy_d    = busy_q;
		retries_d = retries_q;
		wait_d    = wait_q;
		count_d   = count_q;
		action_d  = arbc_pkg::ACT_NONE;
		do_retry  = 1'b0;
		expired   = count_q <= {{(arbc_pkg::TimeW-1){1'b0}}, 1'b1};
		if (opcode_s1 == arbc_pkg::OP_START) begin
			retries_d = '0;
			wait_d    = first_timeout_q;
			if (retry_limit_q == '0) begin
				busy_d   = 1'b0;
				action_d = arbc_pkg::ACT_DEAD;
			end else begin
				busy_d   = 1'b1;
				count_d  = first_timeout_q;
				action_d = arbc_pkg::ACT_TRANSMIT;
			end
		end else if (busy_q) begin
			case (opcode_s1)
				arbc_pkg::OP_TICK: begin
					if (expired) begin
						count_d  = '0;
						do_retry = 1'b1;
					end else begin
						count_d = count_q - 1'b1;
					end
				end
				arbc_pkg::OP_INTERRUPT: do_retry = 1'b1;
				arbc_pkg::OP_RESPONSE: begin
					case (kind_s1)
						arbc_pkg::RSP_ACCEPTED: begin
							busy_d   = 1'b0;
							action_d = arbc_pkg::ACT_SUCCESS;
						end
						arbc_pkg::RSP_MALFORMED: do_retry = 1'b1;
						arbc_pkg::RSP_FATAL: begin
							busy_d   = 1'b0;
							action_d = arbc_pkg::ACT_FAILURE;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
			if (do_retry) begin
				retries_d = retry_inc;
				wait_d    = capped;
				if (retry_tx) begin
					count_d  = capped;
					action_d = arbc_pkg::ACT_TRANSMIT;
				end else begin
					busy_d   = 1'b0;
					action_d = arbc_pkg::ACT_DEAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			retries_q <= '0;
			wait_q    <= '0;
			count_q   <= '0;
		end else if (valid_s1 && advance) begin
			busy_q    <= busy_d;
			retries_q <= retries_d;
			wait_q    <= wait_d;
			count_q   <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			action_q      <= action_d;
			retry_count_q <= retries_d;
			wait_now_q    <= wait_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = action_q;
	assign retry_count = retry_count_q;
	assign wait_now    = wait_now_q;

endmodule

// ===== hdl/arbc_checker.sv =====
// Port-level checker for the retransmission backoff controller, with its bind.
`include "ack_retransmit_backoff_controller_unit_defines.svh"

module arbc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [2:0]                    action,
	input logic [arbc_pkg::RetryW-1:0]   retry_count,
	input logic [arbc_pkg::TimeW-1:0]    wait_now
);

	// A result held back by the consumer must not change.
	`ARBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(action) && $stable(retry_count) && $stable(wait_now), "stalled result changed")

	// A fresh result always comes from an accepted request, via the input and result registers.
	`ARBC_ASSERT_NOW(a_latency, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without a matching request")

	// A retransmission is only ordered below the retry limit, which never exceeds the count range.
	`ARBC_ASSERT_NOW(a_tx_count, out_valid && action == arbc_pkg::ACT_TRANSMIT, retry_count != arbc_pkg::RetryMax, "transmit at saturated retry count")

endmodule

bind ack_retransmit_backoff_controller_unit arbc_checker u_arbc_checker (.*);

// ===== dv/backoff_result_checker.sv =====
// Result checker of the backoff controller: predicts every result from accepted requests.
module backoff_result_checker
	import arbc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [1:0]          response_kind,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [2:0]          action,
	input  logic [RetryW-1:0]   retry_count,
	input  logic [TimeW-1:0]    wait_now,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int                  mismatches,
	output int                  outstanding,
	output int                  results_seen,
	output int                  deaths_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		action_t            act;
		logic [RetryW-1:0]  retries;
		logic [TimeW-1:0]   wait_ticks;
	} outcome_t;

	outcome_t expected_outcomes[$];

	// Shadow copy of the registers and of the controller state.
	logic [TimeW-1:0]  first_wait;
	logic [TimeW-1:0]  wait_cap;
	logic [RetryW-1:0] send_limit;
	logic              active;
	logic [RetryW-1:0] retries;
	logic [TimeW-1:0]  wait_ticks;
	logic [TimeW-1:0]  ticks_left;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// One retry: the count rises, the wait doubles in 17 bits and is capped afterward.
	task automatic back_off(output action_t act);
		logic [TimeW:0] doubled;
		if (retries != RetryMax)
			retries++;
		doubled = {1'b0, wait_ticks} << 1;
		if (doubled > {1'b0, wait_cap})
			doubled = {1'b0, wait_cap};
		wait_ticks = doubled[TimeW-1:0];
		if (retries < send_limit) begin
			ticks_left = wait_ticks;
			act = ACT_TRANSMIT;
		end else begin
			active = 1'b0;
			act = ACT_DEAD;
		end
	endtask

	task automatic advance_controller(input opcode_t op, input resp_kind_t kind,
			output outcome_t res);
		action_t act;
		act = ACT_NONE;
		if (op == OP_START) begin
			retries = '0;
			wait_ticks = first_wait;
			if (send_limit == '0) begin
				active = 1'b0;
				act = ACT_DEAD;
			end else begin
				active = 1'b1;
				ticks_left = wait_ticks;
				act = ACT_TRANSMIT;
			end
		end else if (active) begin
			case (op)
				OP_TICK: begin
					if (ticks_left <= 1) begin
						ticks_left = '0;
						back_off(act);
					end else
						ticks_left--;
				end
				OP_INTERRUPT: back_off(act);
				OP_RESPONSE: begin
					case (kind)
						RSP_ACCEPTED: begin
							active = 1'b0;
							act = ACT_SUCCESS;
						end
						RSP_MALFORMED: back_off(act);
						RSP_FATAL: begin
							active = 1'b0;
							act = ACT_FAILURE;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		res = '{act, retries, wait_ticks};
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t predicted;
		outcome_t oldest;
		if (!arst_n) begin
			first_wait = FirstTimeoutRst;
			wait_cap = TimeoutCapRst;
			send_limit = RetryLimitRst;
			active = 1'b0;
			retries = '0;
			wait_ticks = '0;
			ticks_left = '0;
			expected_outcomes.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FIRST_TIMEOUT: first_wait = cfg_data[TimeW-1:0];
					CFG_TIMEOUT_CAP:   wait_cap = cfg_data[TimeW-1:0];
					CFG_RETRY_LIMIT:   send_limit = cfg_data[RetryW-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_outcomes.size() == 0)
					report_mismatch($sformatf("result with no request pending, action %0d",
						action));
				else begin
					oldest = expected_outcomes.pop_front();
					if (oldest.act == ACT_DEAD)
						deaths_seen++;
					if (action !== oldest.act)
						report_mismatch($sformatf("result %0d action %0d, expected %0d",
							results_seen, action, oldest.act));
					if (retry_count !== oldest.retries)
						report_mismatch($sformatf("result %0d retry_count %0d, expected %0d",
							results_seen, retry_count, oldest.retries));
					if (wait_now !== oldest.wait_ticks)
						report_mismatch($sformatf("result %0d wait_now %0d, expected %0d",
							results_seen, wait_now, oldest.wait_ticks));
				end
			end
			if (in_valid && !in_stall) begin
				advance_controller(opcode_t'(opcode), resp_kind_t'(response_kind), predicted);
				expected_outcomes.push_back(predicted);
			end
			outstanding <= expected_outcomes.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the backoff controller testbench: clock, reset, request stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import arbc_pkg::*;

	localparam int HoldCycles = 80;
	localparam int ItemTarget = 1600;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic [1:0]          opcode = '0;
	logic [1:0]          response_kind = '0;
	logic                out_stall = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_stall;
	logic                out_valid;
	logic [2:0]          action;
	logic [RetryW-1:0]   retry_count;
	logic [TimeW-1:0]    wait_now;

	int mismatches;
	int outstanding;
	int results_seen;
	int deaths_seen;

	int   send_idle_pct = 14;
	int   stall_pct = 14;
	logic hold_armed = 1'b0;
	logic hold_done = 1'b0;
	int   hold_count = 0;
	int   items_sent = 0;
	int   starts_sent = 0;

	always #5 clk = ~clk;

	ack_retransmit_backoff_controller_unit DUT (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .response_kind,
		.out_valid, .out_stall, .action, .retry_count, .wait_now,
		.cfg_we, .cfg_index, .cfg_data
	);

	backoff_result_checker result_check (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .response_kind,
		.out_valid, .out_stall, .action, .retry_count, .wait_now,
		.cfg_we, .cfg_index, .cfg_data,
		.mismatches, .outstanding, .results_seen, .deaths_seen
	);

	// Result side: random stalls, and once a long hold-off so the block backs up.
	always @(posedge clk) begin
		if (hold_armed && !hold_done) begin
			out_stall <= 1'b1;
			if (hold_count == HoldCycles - 1)
				hold_done <= 1'b1;
			hold_count <= hold_count + 1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results still pending", outstanding);
		$display("testbench failed");
		$finish;
	end

	function automatic resp_kind_t any_kind();
		return resp_kind_t'($urandom_range(3));
	endfunction

	// Offers one request and returns at the edge where it is taken.
	task automatic send_event(input opcode_t op, input resp_kind_t kind);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		response_kind <= kind;
		items_sent++;
		if (op == OP_START)
			starts_sent++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Writes all registers; the unused index gets random data and must change nothing.
	task automatic program_regs(input logic [TimeW-1:0] first, input logic [TimeW-1:0] cap,
			input logic [RetryW-1:0] limit);
		logic [7:0] junk;
		junk = 8'($urandom_range(255));
		cfg_we <= 1'b1;
		cfg_index <= CFG_UNUSED;
		cfg_data <= CfgDataW'($urandom_range(16'hFFFF));
		@(posedge clk);
		cfg_index <= CFG_FIRST_TIMEOUT;
		cfg_data <= first;
		@(posedge clk);
		cfg_index <= CFG_TIMEOUT_CAP;
		cfg_data <= cap;
		@(posedge clk);
		cfg_index <= CFG_RETRY_LIMIT;
		cfg_data <= {junk, limit};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase;
		int n;
		int len;
		int pick;
		int first_now;
		int cap_now;
		int limit_now;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: events while idle change nothing.
		send_event(OP_TICK, any_kind());
		send_event(OP_RESPONSE, RSP_ACCEPTED);
		send_event(OP_RESPONSE, RSP_FATAL);
		send_event(OP_INTERRUPT, any_kind());
		// Expiry by ticks, a rejected save, a malformed reply, an interrupt hitting the cap.
		send_event(OP_START, any_kind());
		repeat (3) send_event(OP_TICK, any_kind());
		send_event(OP_RESPONSE, RSP_REJECTED);
		send_event(OP_RESPONSE, RSP_MALFORMED);
		send_event(OP_INTERRUPT, any_kind());
		send_event(OP_RESPONSE, RSP_ACCEPTED);
		// Restart while busy, then a fatal reply.
		send_event(OP_START, any_kind());
		send_event(OP_START, any_kind());
		send_event(OP_RESPONSE, RSP_FATAL);
		// Interrupts until the retry limit declares the peer dead.
		send_event(OP_START, any_kind());
		repeat (5) send_event(OP_INTERRUPT, any_kind());

		// Zero first wait and zero cap expire on the next tick.
		drain_results();
		program_regs('0, '0, 8'd2);
		send_event(OP_START, any_kind());
		send_event(OP_TICK, any_kind());
		send_event(OP_TICK, any_kind());

		// Zero retry limit: the start itself reports the peer dead.
		drain_results();
		program_regs('1, '1, '0);
		send_event(OP_START, any_kind());

		// Full-scale wait: the doubling overflows 16 bits before the cap.
		drain_results();
		program_regs('1, '1, '1);
		send_event(OP_START, any_kind());
		send_event(OP_INTERRUPT, any_kind());
		send_event(OP_RESPONSE, RSP_FATAL);

		phase = 0;
		while (items_sent < ItemTarget) begin
			drain_results();
			send_idle_pct = (phase == 2 || phase == 3) ? 0 : 14;
			stall_pct <= (phase == 2 || phase == 3) ? 0 : 14;
			pick = $urandom_range(9);
			first_now = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(16'hFFFF)
				: $urandom_range(6, 1);
			pick = $urandom_range(9);
			cap_now = (pick == 0) ? 16'hFFFF : (pick == 1) ? $urandom_range(16'hFFFF)
				: $urandom_range(48);
			pick = $urandom_range(9);
			limit_now = (pick == 0) ? 0 : (pick == 1) ? 255 : (pick == 2) ? $urandom_range(255)
				: $urandom_range(8, 1);
			program_regs(TimeW'(first_now), TimeW'(cap_now), RetryW'(limit_now));
			if (phase == 1)
				hold_armed <= 1'b1;
			n = items_sent + $urandom_range(140, 60);
			while (items_sent < n) begin
				send_event(OP_START, any_kind());
				if (limit_now > 100 && $urandom_range(3) == 0) begin
					// Back-to-back retries carry the count all the way to a high limit.
					repeat (limit_now + 2) begin
						if ($urandom_range(1) == 1)
							send_event(OP_INTERRUPT, any_kind());
						else
							send_event(OP_RESPONSE, RSP_MALFORMED);
					end
				end else begin
					len = $urandom_range(30, 3);
					repeat (len) begin
						pick = $urandom_range(99);
						if (pick < 55)
							send_event(OP_TICK, any_kind());
						else if (pick < 67)
							send_event(OP_INTERRUPT, any_kind());
						else if (pick < 75)
							send_event(OP_RESPONSE, RSP_MALFORMED);
						else if (pick < 83)
							send_event(OP_RESPONSE, RSP_REJECTED);
						else if (pick < 87)
							send_event(OP_RESPONSE, RSP_ACCEPTED);
						else if (pick < 90)
							send_event(OP_RESPONSE, RSP_FATAL);
						else if (pick < 94)
							send_event(OP_START, any_kind());
						else
							send_event(opcode_t'($urandom_range(3)), any_kind());
					end
				end
			end
			phase++;
		end

		drain_results();
		repeat (4) @(posedge clk);
		$display("Covered %0d requests with %0d starts over %0d register settings.",
			items_sent, starts_sent, phase + 4);
		$display("Checked %0d results, %0d of them peer dead; %0d mismatches.",
			results_seen, deaths_seen, mismatches);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/arbc_pkg.sv
hdl/ack_retransmit_backoff_controller_unit.sv
hdl/arbc_checker.sv
dv/backoff_result_checker.sv
dv/testbench.sv
